[design/ufl_pkg.sv]
// shared types and constants for the fill level meter
package ufl_pkg;

  localparam int ECHO_W      = 16;
  localparam int DIST_W      = 19;
  localparam int FILL_W      = 7;
  localparam int BAR_W       = 8;
  localparam int HEIGHT_W    = 20;
  localparam int OFFSET_W    = 8;
  localparam int ECHO_PROD_W = 29;
  localparam int DIST_SHIFT  = 10;
  localparam int NUMER_W     = 20;
  localparam int SPAN_W      = 14;
  localparam int CM_W        = 13;
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W     = 18;

  // echo microseconds to 1/256 cm: (us * 4456) >> 10
  localparam logic [ECHO_PROD_W-1:0] DIST_MUL = ECHO_PROD_W'(4456);
  localparam logic [FILL_W-1:0]      PCT_FULL = FILL_W'(100);
  // ceil(2^24 / 100), exact floor division for products below 2^17
  localparam logic [RECIP_W-1:0]     RECIP_100 = RECIP_W'(167773);

  localparam logic signed [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(7680);
  localparam logic [OFFSET_W-1:0]        OFFSET_RESET = OFFSET_W'(5);

  typedef logic [ECHO_W-1:0]          echo_t;
  typedef logic [DIST_W-1:0]          dist_t;
  typedef logic [FILL_W-1:0]          fill_t;
  typedef logic [BAR_W-1:0]           bar_t;
  typedef logic signed [HEIGHT_W-1:0] height_t;
  typedef logic [OFFSET_W-1:0]        offset_t;

  typedef enum logic {
    KIND_ECHO = 1'b0,
    KIND_CAL  = 1'b1
  } kind_t;

endpackage

[design/ufl_if.sv]
// valid/ready channel interfaces for samples and results
interface ufl_in_if import ufl_pkg::*; ();
  logic  valid;
  logic  ready;
  kind_t kind;
  echo_t echo_us;

  modport source (output valid, output kind, output echo_us, input ready);
  modport sink   (input valid, input kind, input echo_us, output ready);
endinterface

interface ufl_out_if import ufl_pkg::*; ();
  logic    valid;
  logic    ready;
  dist_t   average_q8;
  fill_t   fill_percent;
  bar_t    bar_width;
  height_t height_q8;
  logic    span_invalid;

  modport source (output valid, output average_q8, output fill_percent, output bar_width,
                  output height_q8, output span_invalid, input ready);
  modport sink   (input valid, input average_q8, input fill_percent, input bar_width,
                  input height_q8, input span_invalid, output ready);
endinterface

[design/ultrasonic_fill_level_meter.sv]
// top level of the fill level meter: ring ram, running total, divider and result register
// the fill quotient comes from the one-bit-per-cycle divider of TOT_W bits; a zero span skips it
// throughput: one item at a time; the next input transfer is taken the cycle after the result is registered
// the result register lets the next item start while an untaken result still waits
// reset (synchronous, rst_n low): ring reads as zero via per-entry valid bits, total and pointer
//   zero, height 30 cm, mounting offset 5 cm; no clearing pass is needed
module ultrasonic_fill_level_meter import ufl_pkg::*; #(
  parameter int WINDOW_LEN = 10,
  parameter int BAR_PIXELS = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  ufl_in_if.sink     in_ch,
  ufl_out_if.source  out_ch,
  input  logic       cfg_we,
  input  offset_t    cfg_wdata
);

  localparam int PTR_W      = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int TOT_W      = DIST_W + $clog2(WINDOW_LEN + 1);
  localparam int BAR_PROD_W = $clog2(100 * BAR_PIXELS + 1);
  localparam int RPROD_W    = (BAR_PROD_W + RECIP_W > RECIP_SHIFT + BAR_W) ?
                              BAR_PROD_W + RECIP_W : RECIP_SHIFT + BAR_W;

  // window average by reciprocal: ceil(2^AVG_SHIFT / WINDOW_LEN), exact for any total
  localparam int WIN_LOG_W   = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 0;
  localparam int AVG_SHIFT   = TOT_W + WIN_LOG_W;
  localparam int AVG_RECIP_W = TOT_W + 1;
  localparam int AVG_PROD_W  = TOT_W + AVG_RECIP_W;
  localparam logic [63:0] AVG_RECIP_FULL =
    ((64'd1 << AVG_SHIFT) + 64'(WINDOW_LEN - 1)) / 64'(WINDOW_LEN);
  localparam logic [AVG_RECIP_W-1:0] AVG_RECIP = AVG_RECIP_FULL[AVG_RECIP_W-1:0];

  typedef enum logic [3:0] {
    S_IDLE,
    S_UPD,
    S_AVG,
    S_AVG_W,
    S_CAL,
    S_SPAN,
    S_FILL,
    S_FILL_W,
    S_BAR,
    S_RECIP,
    S_OUT
  } state_t;

  state_t                  state_r;
  kind_t                   kind_r;
  dist_t                   dist_r;
  logic [PTR_W-1:0]        ptr_r;
  logic [WINDOW_LEN-1:0]   ring_vld_r;
  logic [TOT_W-1:0]        total_r;
  logic [TOT_W-1:0]        total_nxt;
  logic [AVG_PROD_W-1:0]   avg_prod_r;
  dist_t                   avg_r;
  height_t                 height_r;
  offset_t                 offset_r;
  logic signed [SPAN_W-1:0]  span_r;
  logic signed [NUMER_W-1:0] numer_r;
  logic                    neg_r;
  logic                    invalid_r;
  fill_t                   fill_r;
  logic [BAR_PROD_W-1:0]   bar_prod_r;
  logic [RPROD_W-1:0]      recip_r;
  logic                    out_vld_r;
  dist_t                   out_avg_r;
  fill_t                   out_fill_r;
  bar_t                    out_bar_r;
  height_t                 out_height_r;
  logic                    out_inv_r;

  // ring ram and divider hookups
  dist_t                   ram_rdata;
  dist_t                   old_dist;
  logic                    ram_we;
  logic [ECHO_PROD_W-1:0]  echo_prod;
  logic                    div_start;
  logic [TOT_W-1:0]        div_num;
  logic [TOT_W-1:0]        div_den;
  logic                    div_done;
  logic [TOT_W-1:0]        div_quo;

  // span and numerator arithmetic
  height_t                 cal_height;
  logic [HEIGHT_W-1:0]     height_mag;
  logic signed [CM_W-1:0]  height_cm;
  logic signed [CM_W-1:0]  avg_off_diff;
  logic signed [SPAN_W-1:0]  span_val;
  logic signed [NUMER_W-1:0] numer_val;
  logic [NUMER_W-1:0]      numer_mag;
  logic [SPAN_W-1:0]       span_mag;
  logic                    in_fire;
  logic                    out_free;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_vld_r || out_ch.ready;

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_vld_r;
  assign out_ch.average_q8   = out_avg_r;
  assign out_ch.fill_percent = out_fill_r;
  assign out_ch.bar_width    = out_bar_r;
  assign out_ch.height_q8    = out_height_r;
  assign out_ch.span_invalid = out_inv_r;

  // distance in 1/256 cm, the shift keeps the top nineteen bits
  assign echo_prod = ECHO_PROD_W'(in_ch.echo_us) * DIST_MUL;

  // the ring entry is only trusted once written since reset
  assign old_dist  = ring_vld_r[ptr_r] ? ram_rdata : '0;
  assign total_nxt = total_r - TOT_W'(old_dist) + TOT_W'(dist_r);
  assign ram_we    = (state_r == S_UPD) && (kind_r == KIND_ECHO);

  ufl_ram #(
    .WIDTH (DIST_W),
    .DEPTH (WINDOW_LEN)
  ) u_ring (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ptr_r),
    .wdata   (dist_r),
    .raddr   (ptr_r),
    .rdata_r (ram_rdata)
  );

  // height from the current average less the offset, both in 1/256 cm
  assign cal_height = $signed({1'b0, avg_r}) - $signed({4'b0, offset_r, 8'b0});

  // whole-cm height truncated toward zero
  assign height_mag   = height_r[HEIGHT_W-1] ? HEIGHT_W'(-height_r) : HEIGHT_W'(height_r);
  assign height_cm    = height_r[HEIGHT_W-1] ? -$signed({1'b0, height_mag[HEIGHT_W-1:8]})
                                             :  $signed({1'b0, height_mag[HEIGHT_W-1:8]});
  assign span_val     = $signed({height_cm[CM_W-1], height_cm}) - $signed({6'b0, offset_r});
  assign avg_off_diff = $signed({2'b0, avg_r[DIST_W-1:8]}) - $signed({5'b0, offset_r});
  assign numer_val    = $signed(NUMER_W'(avg_off_diff)) * $signed(NUMER_W'(PCT_FULL));

  // magnitudes for the unsigned divider, the quotient sign is kept aside
  assign numer_mag = numer_r[NUMER_W-1] ? NUMER_W'(-numer_r) : NUMER_W'(numer_r);
  assign span_mag  = span_r[SPAN_W-1] ? SPAN_W'(-span_r) : SPAN_W'(span_r);

  // the divider only serves the fill quotient
  always_comb begin
    div_start = 1'b0;
    div_num   = TOT_W'(numer_mag);
    div_den   = TOT_W'(span_mag);
    case (state_r)
      S_FILL: begin
        div_start = (span_r != '0);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  ufl_div #(
    .W (TOT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done_r   (div_done),
    .quo_r    (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      ptr_r      <= '0;
      ring_vld_r <= '0;
      total_r    <= '0;
      height_r   <= HEIGHT_RESET;
      offset_r   <= OFFSET_RESET;
      out_vld_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        offset_r <= cfg_wdata;
      end
      // in S_OUT the result register is reloaded instead
      if (out_vld_r && out_ch.ready && state_r != S_OUT) begin
        out_vld_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            kind_r  <= in_ch.kind;
            dist_r  <= echo_prod[ECHO_PROD_W-1:DIST_SHIFT];
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          // ram read of the oldest entry has landed
          if (kind_r == KIND_ECHO) begin
            total_r           <= total_nxt;
            ring_vld_r[ptr_r] <= 1'b1;
            ptr_r             <= (ptr_r == PTR_W'(WINDOW_LEN - 1)) ? '0 : ptr_r + 1'b1;
          end
          state_r <= S_AVG;
        end
        S_AVG: begin
          // total times the window reciprocal
          avg_prod_r <= AVG_PROD_W'(total_r) * AVG_PROD_W'(AVG_RECIP);
          state_r    <= S_AVG_W;
        end
        S_AVG_W: begin
          avg_r   <= avg_prod_r[AVG_SHIFT +: DIST_W];
          state_r <= S_CAL;
        end
        S_CAL: begin
          if (kind_r == KIND_CAL) begin
            height_r <= cal_height;
          end
          state_r <= S_SPAN;
        end
        S_SPAN: begin
          span_r  <= span_val;
          numer_r <= numer_val;
          state_r <= S_FILL;
        end
        S_FILL: begin
          neg_r <= numer_r[NUMER_W-1] ^ span_r[SPAN_W-1];
          if (span_r == '0) begin
            invalid_r <= 1'b1;
            fill_r    <= '0;
            state_r   <= S_BAR;
          end else begin
            invalid_r <= 1'b0;
            state_r   <= S_FILL_W;
          end
        end
        S_FILL_W: begin
          if (div_done) begin
            // a negative quotient only raises the level past full
            if (neg_r) begin
              fill_r <= PCT_FULL;
            end else if (div_quo >= TOT_W'(PCT_FULL)) begin
              fill_r <= '0;
            end else begin
              fill_r <= PCT_FULL - div_quo[FILL_W-1:0];
            end
            state_r <= S_BAR;
          end
        end
        S_BAR: begin
          bar_prod_r <= BAR_PROD_W'(fill_r) * BAR_PROD_W'(BAR_PIXELS);
          state_r    <= S_RECIP;
        end
        S_RECIP: begin
          recip_r <= RPROD_W'(bar_prod_r) * RPROD_W'(RECIP_100);
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_vld_r    <= 1'b1;
            out_avg_r    <= avg_r;
            out_fill_r   <= fill_r;
            out_bar_r    <= recip_r[RECIP_SHIFT +: BAR_W];
            out_height_r <= height_r;
            out_inv_r    <= invalid_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) in_fire |=> !in_ch.ready)
    else $error("second transfer taken while an item is in progress");
  assert property (@(posedge clk) disable iff (!rst_n) ptr_r <= PTR_W'(WINDOW_LEN - 1))
    else $error("ring pointer beyond the window");
  assert property (@(posedge clk) disable iff (!rst_n)
                   out_vld_r && out_inv_r |-> out_fill_r == '0 && out_bar_r == '0)
    else $error("zero span result carries a level");
  assert property (@(posedge clk) disable iff (!rst_n) out_vld_r |-> out_fill_r <= PCT_FULL)
    else $error("fill beyond full scale");
  assert property (@(posedge clk) disable iff (!rst_n)
                   state_r == S_UPD && kind_r == KIND_CAL |=> $stable(total_r))
    else $error("calibrate item disturbed the running total");

endmodule

[design/ufl_ram.sv]
// generic single-port-write, registered-read ram
module ufl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
  input  logic [WIDTH-1:0]                    wdata,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
  output logic [WIDTH-1:0]                    rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

[design/ufl_div.sv]
// iterative restoring divider, one quotient bit per cycle
module ufl_div #(
  parameter int W = 23
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done_r,
  output logic [W-1:0] quo_r
);

  localparam int CNT_W = $clog2(W + 1);

  logic [W-1:0]     rem_r;
  logic [W-1:0]     den_r;
  logic [CNT_W-1:0] cnt_r;
  logic [W:0]       shifted;
  logic [W:0]       diff;

  assign shifted = {rem_r, quo_r[W-1]};
  assign diff    = shifted - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CNT_W'(W);
        rem_r <= '0;
        quo_r <= dividend;
        den_r <= divisor;
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        // borrow in the top bit means the trial subtract failed
        if (!diff[W]) begin
          rem_r <= diff[W-1:0];
          quo_r <= {quo_r[W-2:0], 1'b1};
        end else begin
          rem_r <= shifted[W-1:0];
          quo_r <= {quo_r[W-2:0], 1'b0};
        end
        done_r <= (cnt_r == CNT_W'(1));
      end
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) start |=> !done_r)
    else $error("divider finished straight after start");
  assert property (@(posedge clk) disable iff (!rst_n) done_r |-> cnt_r == '0)
    else $error("divider done while still iterating");
  assert property (@(posedge clk) disable iff (!rst_n) done_r |=> !done_r)
    else $error("divider done held for two cycles");

endmodule

[dv/testbench.sv]
// self-checking testbench for the ultrasonic fill level meter
`timescale 1ns / 100ps

module testbench import ufl_pkg::*; ();

  // block configuration under test
  localparam int WINDOW = 10;
  localparam int BAR_PX = 128;

  // echo microseconds to 1/256 cm is us * 4456 / 1024
  localparam int US_TO_Q8_MUL   = 4456;
  localparam int US_TO_Q8_SHIFT = 10;

  // phases of random stimulus, each with its own mounting offset
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_SAMPLES  = 225;
  // receiver long hold-off: length and the result counts at which it starts
  localparam int HOLD_CYCLES    = 300;
  localparam int FIRST_HOLD_AT  = 500;
  localparam int HOLD_SPACING   = 900;
  // quiet time after the last result
  localparam int SETTLE_CYCLES  = 80;

  typedef struct packed {
    kind_t kind;
    echo_t echo_us;
  } sample_t;

  // one expected reading, in the field order of the result channel
  typedef struct packed {
    dist_t   average_q8;
    fill_t   fill_percent;
    bar_t    bar_width;
    height_t height_q8;
    logic    span_invalid;
  } reading_t;

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    cfg_we = 1'b0;
  offset_t cfg_wdata = '0;

  ufl_in_if  in_bus ();
  ufl_out_if out_bus ();

  ultrasonic_fill_level_meter #(
    .WINDOW_LEN (WINDOW),
    .BAR_PIXELS (BAR_PX)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ------------------------------------------------------------------
  // queues shared between stimulus, driver and monitor
  // ------------------------------------------------------------------
  sample_t  samples_q[$];       // samples waiting to be offered
  reading_t readings_due_q[$];  // predicted readings, oldest first

  bit      no_gaps = 1'b0;      // both sides drop their random gaps while set; receiver hold-offs still apply
  offset_t offset_set;          // offset most recently written, for stimulus shaping
  int      samples_queued;
  int      offsets_written;

  // run statistics
  int fails;
  int samples_taken;
  int calibrations_taken;
  int readings_checked;
  int invalid_seen;
  int empty_seen;
  int full_seen;
  int below_zero_seen;

  // ------------------------------------------------------------------
  // gauge model: its own ring, total, pointer, height and offset
  // ------------------------------------------------------------------
  dist_t        gauge_ring[WINDOW];
  logic [22:0]  gauge_total;
  int unsigned  gauge_slot;
  height_t      gauge_height;
  offset_t      gauge_offset;

  function automatic reading_t predict_reading(kind_t kind, echo_t echo_us);
    logic [28:0] echo_prod;
    dist_t       dist_q8;
    logic [22:0] avg_full;
    int          off;
    int          avg_cm;
    int          height_cm;
    int          span;
    int          fill;
    reading_t    r;
    if (kind == KIND_ECHO) begin
      echo_prod = 29'(echo_us) * 29'(US_TO_Q8_MUL);
      dist_q8 = dist_t'(echo_prod >> US_TO_Q8_SHIFT);
      // swap the oldest distance out of the window total
      gauge_total = gauge_total - 23'(gauge_ring[gauge_slot]) + 23'(dist_q8);
      gauge_ring[gauge_slot] = dist_q8;
      gauge_slot = (gauge_slot == WINDOW - 1) ? 0 : gauge_slot + 1;
    end
    avg_full = gauge_total / 23'(WINDOW);
    off = int'(gauge_offset);
    // calibration takes the current average as the empty level
    if (kind == KIND_CAL)
      gauge_height = height_t'(int'(avg_full) - off * 256);
    avg_cm = int'(avg_full >> 8);
    // int division truncates toward zero, as the height conversion needs
    height_cm = int'(gauge_height) / 256;
    span = height_cm - off;
    r.average_q8   = dist_t'(avg_full);
    r.height_q8    = gauge_height;
    r.span_invalid = (span == 0);
    if (r.span_invalid) begin
      fill = 0;
    end else begin
      fill = 100 - ((avg_cm - off) * 100) / span;
      if (fill < 0)
        fill = 0;
      if (fill > 100)
        fill = 100;
    end
    r.fill_percent = fill_t'(fill);
    r.bar_width    = r.span_invalid ? '0 : bar_t'((fill * BAR_PX) / 100);
    return r;
  endfunction

  task automatic check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  // ------------------------------------------------------------------
  // driver: offers queued samples, with random gaps between transfers
  // ------------------------------------------------------------------
  always @(posedge clk) begin : drive_samples
    sample_t next_sample;
    if (!rst_n) begin
      in_bus.valid   <= 1'b0;
      in_bus.kind    <= KIND_ECHO;
      in_bus.echo_us <= '0;
    end else if (!in_bus.valid || in_bus.ready) begin
      // previous sample gone (or none offered): pick up the next one or idle
      if (samples_q.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 21)) begin
        next_sample     = samples_q.pop_front();
        in_bus.valid   <= 1'b1;
        in_bus.kind    <= next_sample.kind;
        in_bus.echo_us <= next_sample.echo_us;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------
  // receiver: random back-pressure plus long hold-offs counted here
  // ------------------------------------------------------------------
  int hold_left;
  int results_taken;
  int next_hold_at;

  always @(posedge clk) begin : take_readings
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      hold_left     <= 0;
      results_taken <= 0;
      next_hold_at  <= FIRST_HOLD_AT;
    end else begin
      if (out_bus.valid && out_bus.ready)
        results_taken <= results_taken + 1;
      if (hold_left != 0) begin
        out_bus.ready <= 1'b0;
        hold_left     <= hold_left - 1;
      end else if (results_taken >= next_hold_at && in_bus.valid) begin
        // only start a hold-off while the sender is still offering, so the block backs up
        out_bus.ready <= 1'b0;
        hold_left     <= HOLD_CYCLES;
        next_hold_at  <= next_hold_at + HOLD_SPACING;
      end else begin
        out_bus.ready <= no_gaps || ($urandom_range(0, 99) >= 21);
      end
    end
  end

  // ------------------------------------------------------------------
  // monitor: tracks offset writes, predicts on each sample transfer and
  // checks each result transfer against the oldest prediction
  // ------------------------------------------------------------------
  always @(posedge clk) begin : watch_gauge
    reading_t want;
    if (!rst_n) begin
      foreach (gauge_ring[i])
        gauge_ring[i] = '0;
      gauge_total  = '0;
      gauge_slot   = 0;
      gauge_height = height_t'(7680);
      gauge_offset = offset_t'(5);
    end else begin
      if (cfg_we)
        gauge_offset = cfg_wdata;

      if (out_bus.valid && out_bus.ready) begin
        if (readings_due_q.size() == 0) begin
          $error("reading transfer with no reading due: average_q8 %0d", out_bus.average_q8);
          fails++;
        end else begin
          want = readings_due_q.pop_front();
          check_field("average_q8",   want.average_q8,   out_bus.average_q8);
          check_field("fill_percent", want.fill_percent, out_bus.fill_percent);
          check_field("bar_width",    want.bar_width,    out_bus.bar_width);
          check_field("height_q8",    want.height_q8,    out_bus.height_q8);
          check_field("span_invalid", want.span_invalid, out_bus.span_invalid);
          readings_checked++;
          if (want.span_invalid)
            invalid_seen++;
          else if (want.fill_percent == 0)
            empty_seen++;
          else if (want.fill_percent == 100)
            full_seen++;
          if (want.height_q8 < 0)
            below_zero_seen++;
        end
      end

      if (in_bus.valid && in_bus.ready) begin
        readings_due_q.push_back(predict_reading(in_bus.kind, in_bus.echo_us));
        samples_taken++;
        if (in_bus.kind == KIND_CAL)
          calibrations_taken++;
      end
    end
  end

  // ------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------
  task automatic queue_sample(kind_t kind, int echo_us);
    sample_t s;
    if (echo_us < 0)
      echo_us = 0;
    if (echo_us > 65535)
      echo_us = 65535;
    s.kind    = kind;
    s.echo_us = echo_t'(echo_us);
    samples_q.push_back(s);
    samples_queued++;
  endtask

  // sender pause: nothing pending, nothing on the bus, every reading in
  task automatic wait_drained();
    do
      @(negedge clk);
    while (samples_q.size() != 0 || in_bus.valid || readings_due_q.size() != 0);
  endtask

  task automatic write_offset(offset_t value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    offset_set = value;
    offsets_written++;
  endtask

  // one fill cycle: settle at an empty-tank distance, calibrate, then wander
  // around nearer levels so the percentage moves across its range
  task automatic queue_tank_cycle();
    int empty_us;
    int level_us;
    int lowest_us;
    // the span loses the offset twice, so the empty level sits beyond 2 * offset
    lowest_us = (2 * int'(offset_set) + 8) * 59;
    empty_us  = $urandom_range(lowest_us, 65535);
    repeat (WINDOW + $urandom_range(0, 4))
      queue_sample(KIND_ECHO, empty_us + $urandom_range(0, 80) - 40);
    queue_sample(KIND_CAL, $urandom_range(0, 65535));
    level_us = $urandom_range(0, empty_us);
    repeat ($urandom_range(5, 30)) begin
      level_us = level_us + $urandom_range(0, 600) - 300;
      if (level_us < 0)
        level_us = 0;
      queue_sample(KIND_ECHO, level_us);
    end
  endtask

  // unstructured samples: any echo width, biased towards small ones, some calibrations
  task automatic queue_noise();
    repeat ($urandom_range(1, 8))
      queue_sample(($urandom_range(0, 99) < 25) ? KIND_CAL : KIND_ECHO,
                   $urandom_range(0, 65535) >> $urandom_range(0, 15));
  endtask

  // ------------------------------------------------------------------
  // stimulus
  // ------------------------------------------------------------------
  initial begin : stimulus
    int phase_idx;
    int phase_start;
    offset_set     = offset_t'(5);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset offset and height: field extremes, calibrations on a part-filled ring
    queue_sample(KIND_ECHO, 0);
    queue_sample(KIND_ECHO, 16'hFFFF);
    queue_sample(KIND_ECHO, 16'hFFFF);
    queue_sample(KIND_ECHO, 16'h0001);
    queue_sample(KIND_ECHO, 16'h8000);
    queue_sample(KIND_CAL,  16'hFFFF);
    queue_sample(KIND_ECHO, 16'h7FFF);
    queue_sample(KIND_CAL,  0);
    wait_drained();

    // zero offset, ring flushed to zero, calibrate: zero span, flag stays up after
    write_offset(8'd0);
    repeat (WINDOW)
      queue_sample(KIND_ECHO, 0);
    queue_sample(KIND_CAL, 16'h5555);
    queue_sample(KIND_ECHO, 0);
    wait_drained();

    // largest offset: calibrating near zero gives a negative height
    write_offset(8'hFF);
    queue_sample(KIND_CAL, 16'hAAAA);
    queue_sample(KIND_ECHO, 16'h00FF);
    queue_sample(KIND_CAL, 0);
    wait_drained();

    // random phases, each after a fresh offset write with the block idle
    for (phase_idx = 0; phase_idx < RANDOM_PHASES; phase_idx++) begin
      case (phase_idx)
        0:       write_offset(8'd5);
        1:       write_offset(8'd0);
        2:       write_offset(8'hFF);
        4:       write_offset(8'd1);
        5:       write_offset(8'hFE);
        7:       write_offset(offset_t'($urandom_range(0, 40)));
        default: write_offset(offset_t'($urandom_range(0, 255)));
      endcase
      // one phase runs with no gaps on either side
      no_gaps = (phase_idx == 3);
      phase_start = samples_queued;
      while (samples_queued - phase_start < PHASE_SAMPLES) begin
        if ($urandom_range(0, 99) < 75)
          queue_tank_cycle();
        else
          queue_noise();
      end
      wait_drained();
    end
    no_gaps = 1'b0;

    // anything still arriving now is unexpected
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("run covered %0d samples, %0d of them calibrations, over %0d offset writes",
             samples_taken, calibrations_taken, offsets_written);
    $display("%0d readings checked: %0d span invalid, %0d empty, %0d full, %0d below zero height",
             readings_checked, invalid_seen, empty_seen, full_seen, below_zero_seen);
    if (fails == 0)
      $display("ultrasonic_fill_level_meter verification clean");
    else
      $display("ultrasonic_fill_level_meter verification failed");
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin : watchdog
    #10_000_000;
    $display("ultrasonic_fill_level_meter verification failed");
    $finish;
  end

endmodule

[files.f]
design/ufl_pkg.sv
design/ufl_if.sv
design/ufl_ram.sv
design/ufl_div.sv
design/ultrasonic_fill_level_meter.sv
dv/testbench.sv
